// File: hdl/cbfm_pkg.sv
// Package for the clock-replacement buffer frame manager.
// Holds widths, request, status and fill codes. No dependencies.
package cbfm_pkg;
  localparam int NumFramesDef = 16;
  localparam int PageBitsDef  = 20;
  localparam int FileBitsDef  = 8;
  localparam int CfgBits      = 5;
  localparam int IdxBits      = 4;

  typedef enum logic [2:0] {
    REQ_PIN = 3'd0, REQ_UNPIN = 3'd1, REQ_ALLOC = 3'd2, REQ_DISPOSE = 3'd3,
    REQ_FLUSH = 3'd4
  } req_e;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StAllPinned = 3'd1;
  localparam logic [2:0] StNotFound  = 3'd2;
  localparam logic [2:0] StNotPinned = 3'd3;
  localparam logic [2:0] StPagePin   = 3'd4;

  localparam logic [1:0] FillNone = 2'd0;
  localparam logic [1:0] FillRead = 2'd1;
  localparam logic [1:0] FillZero = 2'd2;
endpackage

// File: hdl/cbfm_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on cbfm_pkg.
interface cbfm_req_if import cbfm_pkg::*; #(
  parameter int PageBits = PageBitsDef,
  parameter int FileBits = FileBitsDef
);
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic [FileBits-1:0] file_id;
  logic [PageBits-1:0] page_no;
  logic                mark_dirty;
  modport source (output valid, req_type, file_id, page_no, mark_dirty, input ready);
  modport sink (input valid, req_type, file_id, page_no, mark_dirty, output ready);
endinterface

interface cbfm_rsp_if import cbfm_pkg::*; #(
  parameter int PageBits = PageBitsDef,
  parameter int FileBits = FileBitsDef
);
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [IdxBits-1:0]  frame_index;
  logic [1:0]          fill_kind;
  logic                writeback_valid;
  logic [IdxBits-1:0]  wb_frame;
  logic [FileBits-1:0] wb_file_id;
  logic [PageBits-1:0] wb_page_no;
  logic                last;
  modport source (output valid, status, frame_index, fill_kind, writeback_valid, wb_frame,
                  wb_file_id, wb_page_no, last, input ready);
  modport sink (input valid, status, frame_index, fill_kind, writeback_valid, wb_frame,
                wb_file_id, wb_page_no, last, output ready);
endinterface

interface cbfm_cfg_if import cbfm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hdl/cbfm_datapath.sv
// Frame table datapath: tag match, frame fields, clock hand, request latch.
// Depends on cbfm_pkg; driven by commands from cbfm_ctrl.
module cbfm_datapath import cbfm_pkg::*; #(
  parameter int NumFrames = NumFramesDef,
  parameter int PageBits  = PageBitsDef,
  parameter int FileBits  = FileBitsDef,
  localparam int FBits    = $clog2(NumFrames + 1),
  localparam int IBits    = $clog2(NumFrames)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgBits-1:0]  cfg_data_i,
  input  logic                latch_i,     // capture request, run match
  input  logic [FileBits-1:0] file_i,
  input  logic [PageBits-1:0] page_i,
  input  logic                md_i,
  input  logic                do_hit_i,    // pin hit update
  input  logic                do_unpin_i,
  input  logic                do_dispose_i,
  input  logic                sweep_step_i,// advance hand and examine
  input  logic                fill_i,      // fill hand frame
  input  logic                walk_clr_i,  // reset walk index
  input  logic                walk_step_i, // empty own-file frame, advance
  output logic                hit_o,
  output logic [IBits-1:0]    match_o,
  output logic                m_pinned_o,
  output logic                h_take_o,    // frame at next hand is takeable
  output logic                h_dirty_o,
  output logic [IBits-1:0]    h_next_o,
  output logic [IBits-1:0]    hand_o,
  output logic [FBits:0]      two_n_o,
  output logic                w_done_o,
  output logic                w_mine_o,
  output logic                w_pinned_o,
  output logic                w_dirty_o,
  output logic [IBits-1:0]    w_idx_o,
  output logic [FileBits-1:0] rd_file_o,
  output logic [PageBits-1:0] rd_page_o
);
  logic [CfgBits-1:0]  fiu_q;
  logic [NumFrames-1:0] valid_q, dirty_q, ref_q;
  logic [FileBits-1:0] file_q [NumFrames];
  logic [PageBits-1:0] page_q [NumFrames];
  logic [7:0]          pins_q [NumFrames];
  logic [IBits-1:0]    hand_q, match_q;
  logic [FBits-1:0]    walk_q;
  logic                hit_q;
  logic [FileBits-1:0] rf_q;
  logic [PageBits-1:0] rp_q;
  logic                md_q;
  logic [FBits-1:0]    n;
  logic [NumFrames-1:0] mv;
  logic [IBits-1:0]    mi, hn, rdi, wi;

  always_comb begin
    if (fiu_q == '0) n = FBits'(1);
    else if (CfgBits'(fiu_q) > CfgBits'(NumFrames) && NumFrames < 32) n = FBits'(NumFrames);
    else n = FBits'(fiu_q);
  end

  always_comb begin
    for (int i = 0; i < NumFrames; i++) begin
      mv[i] = valid_q[i] && file_q[i] == file_i && page_q[i] == page_i && FBits'(i) < n;
    end
    mi = '0;
    for (int i = NumFrames - 1; i >= 0; i--) begin
      if (mv[i]) mi = IBits'(i);
    end
  end

  assign wi = walk_q[IBits-1:0];
  assign hn = ((FBits'(hand_q) + FBits'(1)) >= n) ? '0 : hand_q + IBits'(1);
  assign h_next_o = hn;
  assign h_take_o = !valid_q[hn] || (!ref_q[hn] && pins_q[hn] == '0);
  assign h_dirty_o = valid_q[hn] && dirty_q[hn];
  assign hit_o = hit_q;
  assign match_o = match_q;
  assign m_pinned_o = pins_q[match_q] != '0;
  assign hand_o = hand_q;
  assign two_n_o = {n, 1'b0};
  assign w_done_o = walk_q >= n;
  assign w_mine_o = valid_q[wi] && file_q[wi] == rf_q;
  assign w_pinned_o = pins_q[wi] != '0;
  assign w_dirty_o = dirty_q[wi];
  assign w_idx_o = wi;
  assign rdi = walk_step_i ? wi : hn;
  assign rd_file_o = file_q[rdi];
  assign rd_page_o = page_q[rdi];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= CfgBits'(16);
      valid_q <= '0; dirty_q <= '0; ref_q <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        file_q[i] <= '0; page_q[i] <= '0; pins_q[i] <= '0;
      end
      hand_q <= (NumFrames < 16) ? IBits'(NumFrames - 1) : IBits'(15);
      walk_q <= '0; match_q <= '0; hit_q <= 1'b0;
      rf_q <= '0; rp_q <= '0; md_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fiu_q <= cfg_data_i;
      end
      if (latch_i) begin
        hit_q <= |mv; match_q <= mi; rf_q <= file_i; rp_q <= page_i; md_q <= md_i;
      end
      if (do_hit_i) begin
        ref_q[match_q] <= 1'b1;
        if (pins_q[match_q] != 8'hff) pins_q[match_q] <= pins_q[match_q] + 8'd1;
      end
      if (do_unpin_i) begin
        pins_q[match_q] <= pins_q[match_q] - 8'd1;
        if (md_q) dirty_q[match_q] <= 1'b1;
      end
      if (do_dispose_i) begin
        valid_q[match_q] <= 1'b0; dirty_q[match_q] <= 1'b0; ref_q[match_q] <= 1'b0;
        file_q[match_q] <= '0; page_q[match_q] <= '0; pins_q[match_q] <= '0;
      end
      if (sweep_step_i) begin
        hand_q <= hn;
        if (ref_q[hn] && valid_q[hn]) ref_q[hn] <= 1'b0;
      end
      if (fill_i) begin
        valid_q[hand_q] <= 1'b1; file_q[hand_q] <= rf_q; page_q[hand_q] <= rp_q;
        pins_q[hand_q] <= 8'd1; dirty_q[hand_q] <= 1'b0; ref_q[hand_q] <= 1'b1;
      end
      if (walk_clr_i) begin
        walk_q <= '0;
      end
      if (walk_step_i) begin
        if (w_mine_o) begin
          valid_q[wi] <= 1'b0; dirty_q[wi] <= 1'b0; ref_q[wi] <= 1'b0;
          file_q[wi] <= '0; page_q[wi] <= '0; pins_q[wi] <= '0;
        end
        walk_q <= walk_q + FBits'(1);
      end
    end
  end
endmodule

// File: hdl/cbfm_ctrl.sv
// Request sequencer: decodes requests, drives sweep and flush walk, and
// holds the result register. Depends on cbfm_pkg and cbfm_datapath status.
module cbfm_ctrl import cbfm_pkg::*; #(
  parameter int NumFrames = NumFramesDef,
  parameter int PageBits  = PageBitsDef,
  parameter int FileBits  = FileBitsDef,
  localparam int FBits    = $clog2(NumFrames + 1),
  localparam int IBits    = $clog2(NumFrames)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          req_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [2:0]          status_o,
  output logic [IdxBits-1:0]  frame_o,
  output logic [1:0]          fill_o,
  output logic                wbv_o,
  output logic [IdxBits-1:0]  wbf_o,
  output logic [FileBits-1:0] wbfile_o,
  output logic [PageBits-1:0] wbpage_o,
  output logic                last_o,
  output logic                latch_o,
  output logic                do_hit_o,
  output logic                do_unpin_o,
  output logic                do_dispose_o,
  output logic                sweep_step_o,
  output logic                fill_cmd_o,
  output logic                walk_clr_o,
  output logic                walk_step_o,
  input  logic                hit_i,
  input  logic [IBits-1:0]    match_i,
  input  logic                m_pinned_i,
  input  logic                h_take_i,
  input  logic                h_dirty_i,
  input  logic [IBits-1:0]    h_next_i,
  input  logic [IBits-1:0]    hand_i,
  input  logic [FBits:0]      two_n_i,
  input  logic                w_done_i,
  input  logic                w_mine_i,
  input  logic                w_pinned_i,
  input  logic                w_dirty_i,
  input  logic [IBits-1:0]    w_idx_i,
  input  logic [FileBits-1:0] rd_file_i,
  input  logic [PageBits-1:0] rd_page_i
);
  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SWEEP, S_FILL, S_WALK, S_OUT} state_e;
  state_e state_q;
  req_e   req_q;
  logic [FBits:0] steps_q;
  logic   walk_more_q; // after output, continue walk

  assign in_ready_o = state_q == S_IDLE;
  assign latch_o = in_valid_i && in_ready_o;
  assign do_hit_o = state_q == S_DECODE && req_q == REQ_PIN && hit_i;
  assign do_unpin_o = state_q == S_DECODE && req_q == REQ_UNPIN && hit_i && m_pinned_i;
  assign do_dispose_o = state_q == S_DECODE && req_q == REQ_DISPOSE && hit_i;
  assign sweep_step_o = state_q == S_SWEEP && steps_q < two_n_i;
  assign fill_cmd_o = state_q == S_FILL;
  assign walk_clr_o = state_q == S_DECODE;
  assign walk_step_o = state_q == S_WALK && !w_done_i && !(w_mine_i && w_pinned_i);

  task automatic res(input logic [2:0] st, input logic [IdxBits-1:0] fi,
                     input logic [1:0] fill, input logic wbv, input logic [IdxBits-1:0] wbf,
                     input logic [FileBits-1:0] wbfile, input logic [PageBits-1:0] wbpage,
                     input logic lst);
    status_o <= st; frame_o <= fi; fill_o <= fill; wbv_o <= wbv;
    wbf_o <= wbf; wbfile_o <= wbfile; wbpage_o <= wbpage; last_o <= lst;
  endtask

  // Final result item with status only.
  task automatic res_st(input logic [2:0] st);
    res(st, '0, FillNone, 1'b0, '0, '0, '0, 1'b1);
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; req_q <= REQ_PIN; steps_q <= '0; walk_more_q <= 1'b0;
      out_valid_o <= 1'b0;
      status_o <= '0; frame_o <= '0; fill_o <= '0; wbv_o <= 1'b0;
      wbf_o <= '0; wbfile_o <= '0; wbpage_o <= '0; last_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (latch_o) begin
            req_q <= req_e'(req_i); state_q <= S_DECODE; steps_q <= '0;
          end
        end
        S_DECODE: begin
          walk_more_q <= 1'b0;
          unique case (req_q)
            REQ_PIN, REQ_ALLOC: begin
              if (hit_i && req_q == REQ_ALLOC) begin
                res_st(StPagePin); out_valid_o <= 1'b1; state_q <= S_OUT;
              end else if (hit_i) begin
                res(StOk, IdxBits'(match_i), FillNone, 1'b0, '0, '0, '0, 1'b1);
                out_valid_o <= 1'b1; state_q <= S_OUT;
              end else begin
                state_q <= S_SWEEP;
              end
            end
            REQ_UNPIN: begin
              out_valid_o <= 1'b1; state_q <= S_OUT;
              if (!hit_i) res_st(StNotFound);
              else if (!m_pinned_i) res_st(StNotPinned);
              else res_st(StOk);
            end
            REQ_DISPOSE: begin
              res_st(StOk); out_valid_o <= 1'b1; state_q <= S_OUT;
            end
            REQ_FLUSH: begin
              state_q <= S_WALK;
            end
            default: begin
              res_st(StNotFound); out_valid_o <= 1'b1; state_q <= S_OUT;
            end
          endcase
        end
        S_SWEEP: begin
          if (steps_q >= two_n_i) begin
            res_st(StAllPinned); out_valid_o <= 1'b1; state_q <= S_OUT;
          end else begin
            steps_q <= steps_q + (FBits+1)'(1);
            if (h_take_i) begin
              if (h_dirty_i) begin
                res(StOk, IdxBits'(h_next_i), (req_q == REQ_PIN) ? FillRead : FillZero,
                    1'b1, IdxBits'(h_next_i), rd_file_i, rd_page_i, 1'b1);
              end else begin
                res(StOk, IdxBits'(h_next_i), (req_q == REQ_PIN) ? FillRead : FillZero,
                    1'b0, '0, '0, '0, 1'b1);
              end
              state_q <= S_FILL;
            end
          end
        end
        S_FILL: begin
          out_valid_o <= 1'b1; state_q <= S_OUT;
        end
        S_WALK: begin
          if (w_done_i) begin
            res_st(StOk); out_valid_o <= 1'b1; state_q <= S_OUT;
          end else if (w_mine_i && w_pinned_i) begin
            res_st(StPagePin); out_valid_o <= 1'b1; state_q <= S_OUT;
          end else if (w_mine_i && w_dirty_i) begin
            res(StOk, '0, FillNone, 1'b1, IdxBits'(w_idx_i), rd_file_i, rd_page_i, 1'b0);
            out_valid_o <= 1'b1; walk_more_q <= 1'b1; state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= walk_more_q ? S_WALK : S_IDLE;
            walk_more_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^hand_i;
endmodule

// File: hdl/clock_buffer_frame_manager_top.sv
// Clock (second-chance) buffer frame manager, top level.
// Hit, unpin and dispose answer from decode; a sweep moves the hand until a frame is
// takeable or all are pinned; a flush adds one item per write-back. One request at a
// time. Reset empties all frames, sets frames_in_use to 16 and hand to min(N-1,15).
// Depends on cbfm_pkg, cbfm_if, cbfm_ctrl, cbfm_datapath.
module clock_buffer_frame_manager_top import cbfm_pkg::*; #(
  parameter int NumFrames = NumFramesDef,
  parameter int PageBits  = PageBitsDef,
  parameter int FileBits  = FileBitsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  cbfm_req_if.sink  req,
  cbfm_rsp_if.source rsp,
  cbfm_cfg_if.sink  cfg
);
  localparam int FBits = $clog2(NumFrames + 1);
  localparam int IBits = $clog2(NumFrames);
  logic latch, do_hit, do_unpin, do_dispose, sweep_step, fill_cmd, walk_clr, walk_step;
  logic hit, m_pinned, h_take, h_dirty, w_done, w_mine, w_pinned, w_dirty;
  logic [IBits-1:0] match, h_next, hand, w_idx;
  logic [FBits:0] two_n;
  logic [FileBits-1:0] rd_file;
  logic [PageBits-1:0] rd_page;

  assign cfg.ready = 1'b1;

  cbfm_datapath #(.NumFrames(NumFrames), .PageBits(PageBits), .FileBits(FileBits)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i(cfg.valid), .cfg_data_i(cfg.data),
    .latch_i(latch), .file_i(req.file_id), .page_i(req.page_no), .md_i(req.mark_dirty),
    .do_hit_i(do_hit), .do_unpin_i(do_unpin), .do_dispose_i(do_dispose),
    .sweep_step_i(sweep_step), .fill_i(fill_cmd), .walk_clr_i(walk_clr),
    .walk_step_i(walk_step), .hit_o(hit), .match_o(match), .m_pinned_o(m_pinned),
    .h_take_o(h_take), .h_dirty_o(h_dirty), .h_next_o(h_next), .hand_o(hand),
    .two_n_o(two_n), .w_done_o(w_done), .w_mine_o(w_mine), .w_pinned_o(w_pinned),
    .w_dirty_o(w_dirty), .w_idx_o(w_idx), .rd_file_o(rd_file), .rd_page_o(rd_page)
  );

  cbfm_ctrl #(.NumFrames(NumFrames), .PageBits(PageBits), .FileBits(FileBits)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(req.valid), .in_ready_o(req.ready), .req_i(req.req_type),
    .out_ready_i(rsp.ready), .out_valid_o(rsp.valid), .status_o(rsp.status),
    .frame_o(rsp.frame_index), .fill_o(rsp.fill_kind), .wbv_o(rsp.writeback_valid),
    .wbf_o(rsp.wb_frame), .wbfile_o(rsp.wb_file_id), .wbpage_o(rsp.wb_page_no),
    .last_o(rsp.last), .latch_o(latch), .do_hit_o(do_hit), .do_unpin_o(do_unpin),
    .do_dispose_o(do_dispose), .sweep_step_o(sweep_step), .fill_cmd_o(fill_cmd),
    .walk_clr_o(walk_clr), .walk_step_o(walk_step), .hit_i(hit), .match_i(match),
    .m_pinned_i(m_pinned), .h_take_i(h_take), .h_dirty_i(h_dirty), .h_next_i(h_next),
    .hand_i(hand), .two_n_i(two_n), .w_done_i(w_done), .w_mine_i(w_mine),
    .w_pinned_i(w_pinned), .w_dirty_i(w_dirty), .w_idx_i(w_idx),
    .rd_file_i(rd_file), .rd_page_i(rd_page)
  );
endmodule
